// File: src/lruc_pkg.sv
// Shared types and constants for the LRU associative cache.
`default_nettype none

package lruc_pkg;

  // Field widths
  localparam int KEY_W     = 32;
  localparam int VALUE_W   = 32;
  localparam int STAMP_W   = 64;
  localparam int ACT_W     = 2;
  localparam int CNT_W     = 5;

  // Stream payload widths
  localparam int S_TDATA_W  = KEY_W + VALUE_W;
  localparam int OUT_RAW_W  = 1 + VALUE_W + 1 + CNT_W;
  localparam int M_TDATA_W  = ((OUT_RAW_W + 7) / 8) * 8;

  // Register port
  localparam int ADDR_W  = 3;
  localparam int PDATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_ACTIVE_SLOTS = 1'b0;
  localparam logic [CNT_W-1:0]  ACTIVE_RESET     = 5'd16;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_PEEK  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_GET   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PUT   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic update;
    logic capture;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } sts_t;

  // Register write towards the slot store
  typedef struct packed {
    logic             wr;
    logic [CNT_W-1:0] lim;
  } cfg_t;

endpackage

`default_nettype wire

// File: src/lruc_regs.sv
// Register port holding the active slot count and its clamped limit.
`default_nettype none

module lruc_regs import lruc_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic      [CNT_W-1:0]   lim,
  output cfg_t                    cfg
);

  localparam int LIM_MAX = (SLOTS < 31) ? SLOTS : 31;

  logic [CNT_W-1:0] active_slots;
  logic             sel_active;
  logic             wr_en;

  // Map the written count onto 1..LIM_MAX
  function automatic logic [CNT_W-1:0] clamp_lim(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > LIM_MAX) begin
      r = CNT_W'(LIM_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign pready     = 1'b1;
  assign sel_active = (paddr[ADDR_W-1:2] == REG_ACTIVE_SLOTS);
  assign wr_en      = psel & penable & pwrite & pready;

  // Hold the active slot count
  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= ACTIVE_RESET;
    end else if (wr_en && sel_active) begin
      active_slots <= pwdata[CNT_W-1:0];
    end
  end

  // Read back and export the limit
  assign prdata  = sel_active ? PDATA_W'(active_slots) : '0;
  assign lim     = clamp_lim(active_slots);
  assign cfg.wr  = wr_en && sel_active;
  assign cfg.lim = clamp_lim(pwdata[CNT_W-1:0]);

endmodule

`default_nettype wire

// File: src/lruc_ctrl.sv
// Sequencer for load, slot scan, update, value read and result hand-off.
`default_nettype none

module lruc_ctrl import lruc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  input  wire sts_t sts,
  output logic      s_tready,
  output cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode commands and the next state
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.capture = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/lruc_dp.sv
// Slot store, scan pipeline, replacement decision and result registers.
`default_nettype none

module lruc_dp import lruc_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic [CNT_W-1:0]   lim,
  input  wire cfg_t               cfg,
  input  wire logic [ACT_W-1:0]   in_action,
  input  wire logic [KEY_W-1:0]   in_key,
  input  wire logic [VALUE_W-1:0] in_value,
  input  wire logic               m_tready,
  output logic                    m_tvalid,
  output logic                    out_hit,
  output logic      [VALUE_W-1:0] out_data,
  output logic                    out_evicted,
  output logic      [CNT_W-1:0]   out_count
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int XW = (IW > CNT_W) ? IW : CNT_W;

  // Captured item
  logic [ACT_W-1:0]   act;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] val;

  // Slot store
  logic [KEY_W-1:0]   key_mem   [SLOTS];
  logic [VALUE_W-1:0] value_mem [SLOTS];
  logic [STAMP_W-1:0] stamp_mem [SLOTS];
  logic [SLOTS-1:0]   slot_valid;
  logic [STAMP_W-1:0] access_clock;

  // Scan pipeline
  logic [XW-1:0]      scan_ptr;
  logic [IW-1:0]      scan_idx;
  logic               issue;
  logic               st_go;
  logic               st_last;
  logic               st_slot_v;
  logic [IW-1:0]      st_idx;
  logic [KEY_W-1:0]   key_rd;
  logic [STAMP_W-1:0] stamp_rd;
  logic [VALUE_W-1:0] value_rd;

  // Scan findings
  logic               found;
  logic [IW-1:0]      found_idx;
  logic               best_v;
  logic [IW-1:0]      best_idx;
  logic [STAMP_W-1:0] best_stamp;
  logic               free_v;
  logic [IW-1:0]      free_idx;
  logic [CNT_W-1:0]   count;

  // Result staging
  logic               res_hit;
  logic               res_evicted;
  logic [CNT_W-1:0]   res_count;
  logic [VALUE_W-1:0] res_data;

  // Update decode
  logic               is_get;
  logic               put_ok;
  logic               full;
  logic               do_refresh;
  logic               do_insert;
  logic [IW-1:0]      ins_idx;
  logic [STAMP_W-1:0] clock_inc;
  logic               stamp_we;
  logic [IW-1:0]      stamp_wa;

  assign scan_idx   = scan_ptr[IW-1:0];
  assign issue      = cmd.scan && (scan_ptr < XW'(lim));
  assign is_get     = (act == ACT_GET);
  assign put_ok     = (act == ACT_PUT) && (val != '0);
  assign do_refresh = found && (is_get || put_ok);
  assign do_insert  = put_ok && !found;
  assign full       = (count >= lim);
  assign ins_idx    = full ? best_idx : free_idx;
  assign clock_inc  = access_clock + STAMP_W'(1);
  assign stamp_we   = cmd.update && (do_refresh || do_insert);
  assign stamp_wa   = do_refresh ? found_idx : ins_idx;

  assign sts.scan_done = st_go && st_last;
  assign sts.out_busy  = m_tvalid && !m_tready;

  // Read and write the slot memories
  always_ff @(posedge clk) begin
    if (issue) begin
      key_rd   <= key_mem[scan_idx];
      stamp_rd <= stamp_mem[scan_idx];
    end
    if (cmd.update) begin
      value_rd <= value_mem[found_idx];
    end
    if (stamp_we) begin
      stamp_mem[stamp_wa] <= clock_inc;
    end
    if (cmd.update && do_insert) begin
      key_mem[ins_idx]   <= key;
      value_mem[ins_idx] <= val;
    end
  end

  // Hold valid bits, access clock, scan pointer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      access_clock <= '0;
      scan_ptr     <= '0;
      st_go        <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg.wr) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (i >= int'(cfg.lim)) begin
            slot_valid[i] <= 1'b0;
          end
        end
      end
      if (cmd.update) begin
        if (act == ACT_CLEAR) begin
          slot_valid <= '0;
        end else if (do_insert && !full) begin
          slot_valid[free_idx] <= 1'b1;
        end
        if (do_refresh || do_insert) begin
          access_clock <= clock_inc;
        end
      end
      if (cmd.load) begin
        scan_ptr <= '0;
        st_go    <= 1'b0;
      end else begin
        st_go <= issue;
        if (issue) begin
          scan_ptr <= scan_ptr + XW'(1);
        end
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Capture the item, track findings and stage the result
  always_ff @(posedge clk) begin
    if (issue) begin
      st_idx    <= scan_idx;
      st_slot_v <= slot_valid[scan_idx];
      st_last   <= (scan_ptr == XW'(lim) - XW'(1));
    end
    if (cmd.load) begin
      act    <= in_action;
      key    <= in_key;
      val    <= in_value;
      found  <= 1'b0;
      best_v <= 1'b0;
      free_v <= 1'b0;
      count  <= '0;
    end else if (st_go) begin
      if (st_slot_v) begin
        count <= count + CNT_W'(1);
      end
      if (st_slot_v && (key_rd == key) && !found) begin
        found     <= 1'b1;
        found_idx <= st_idx;
      end
      // Strict compare keeps the lowest index on a tie
      if (st_slot_v && (!best_v || (stamp_rd < best_stamp))) begin
        best_v     <= 1'b1;
        best_idx   <= st_idx;
        best_stamp <= stamp_rd;
      end
      if (!st_slot_v && !free_v) begin
        free_v   <= 1'b1;
        free_idx <= st_idx;
      end
    end
    if (cmd.update) begin
      res_hit     <= found && (act != ACT_CLEAR) && ((act != ACT_PUT) || (val != '0));
      res_evicted <= do_insert && full;
      if (act == ACT_CLEAR) begin
        res_count <= CNT_W'(0);
      end else if (do_insert && !full) begin
        res_count <= count + CNT_W'(1);
      end else begin
        res_count <= count;
      end
    end
    if (cmd.capture) begin
      res_data <= (is_get && found) ? value_rd : '0;
    end
    if (cmd.emit) begin
      out_hit     <= res_hit;
      out_data    <= res_data;
      out_evicted <= res_evicted;
      out_count   <= res_count;
    end
  end

endmodule

`default_nettype wire

// File: src/lru_associative_cache.sv
// Top level of the fully associative LRU cache with stream and register ports.
// One item at a time: the next is taken only after the last has been scanned, updated,
// read and emitted. The slot scan reads one key and stamp per cycle.
// The next item is taken while an earlier result still waits in the output register.
// Reset (synchronous, active high): all slots invalid, access clock zero, 16 active slots.
// No clearing pass follows reset; items are accepted from the first cycle after it.
`default_nettype none

module lru_associative_cache import lruc_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // key, value
  input  wire logic [ACT_W-1:0]     s_tuser,   // action
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [M_TDATA_W-1:0] m_tdata,   // hit, data, evicted, occupied_count, zero pad
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_W-1:0]    paddr,
  input  wire logic [PDATA_W-1:0]   pwdata,
  output logic      [PDATA_W-1:0]   prdata,
  output logic                      pready
);

  cmd_t               cmd;
  sts_t               sts;
  cfg_t               cfg;
  logic [CNT_W-1:0]   lim;
  logic               out_hit;
  logic [VALUE_W-1:0] out_data;
  logic               out_evicted;
  logic [CNT_W-1:0]   out_count;

  lruc_regs #(.SLOTS(SLOTS)) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .lim     (lim),
    .cfg     (cfg)
  );

  lruc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .sts      (sts),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  lruc_dp #(.SLOTS(SLOTS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .lim         (lim),
    .cfg         (cfg),
    .in_action   (s_tuser),
    .in_key      (s_tdata[KEY_W-1:0]),
    .in_value    (s_tdata[KEY_W +: VALUE_W]),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .out_hit     (out_hit),
    .out_data    (out_data),
    .out_evicted (out_evicted),
    .out_count   (out_count)
  );

  // Pack the result fields, lowest first
  assign m_tdata = M_TDATA_W'({out_count, out_evicted, out_data, out_hit});

endmodule

`default_nettype wire

// File: src/lruc_chk.sv
// Port-level checks for the LRU cache, bound to the top level.
`default_nettype none

module lruc_chk import lruc_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // No result straight after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

  // An eviction only happens on a put that missed
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[33] && m_tdata[0]))
    else $error("eviction reported together with a hit");

  // Returned data comes only from a hit
  a_data_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[32:1] != '0) |-> m_tdata[0])
    else $error("data returned without a hit");

  // After an eviction the new entry occupies a slot
  a_evict_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33] |-> (m_tdata[38:34] != '0))
    else $error("eviction left the cache empty");

endmodule

bind lru_associative_cache lruc_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// File: tb/sv/lru_cache_checker.sv
// Checker for the LRU associative cache: predicts each reply and compares it.
module lru_cache_checker import lruc_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // key, value
  input  logic [ACT_W-1:0]     s_tuser,   // action
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,   // hit, data, evicted, occupied_count, zero pad
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  input  logic                 pready,
  input  logic                 drain_check,
  output int                   fail_count,
  output int                   pending,
  output int                   replies_seen,
  output int                   hits_seen,
  output int                   evictions_seen
);

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] data;
    logic               evicted;
    logic [CNT_W-1:0]   occupied;
  } cache_reply_t;

  // Shadow copy of the slot store
  logic               line_valid [SLOTS];
  logic [KEY_W-1:0]   line_tag   [SLOTS];
  logic [VALUE_W-1:0] line_value [SLOTS];
  logic [STAMP_W-1:0] line_age   [SLOTS];
  logic [STAMP_W-1:0] age_counter;
  logic [CNT_W-1:0]   active_setting;

  cache_reply_t replies_due [$];
  bit           drained;

  initial begin
    fail_count     = 0;
    pending        = 0;
    replies_seen   = 0;
    hits_seen      = 0;
    evictions_seen = 0;
    drained        = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < 40) $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Clamp the register to 1..SLOTS
  function automatic int unsigned slots_in_use();
    if (active_setting == '0) return 1;
    if (active_setting > SLOTS) return SLOTS;
    return 32'(active_setting);
  endfunction

  function automatic int unsigned live_lines();
    int unsigned n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (line_valid[i]) n++;
    return n;
  endfunction

  function automatic int unsigned find_tag(input logic [KEY_W-1:0] tag, input int unsigned lim);
    for (int i = 0; i < lim; i++)
      if (line_valid[i] && line_tag[i] == tag) return i;
    return lim;
  endfunction

  task automatic set_active(input logic [PDATA_W-1:0] wdata);
    int unsigned lim;
    active_setting = wdata[CNT_W-1:0];
    lim = slots_in_use();
    for (int i = lim; i < SLOTS; i++) line_valid[i] = 1'b0;
  endtask

  // Work out the reply for one accepted item and update the shadow store
  task automatic predict_access(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] tag,
                                input logic [VALUE_W-1:0] val);
    cache_reply_t r;
    int unsigned  lim, idx, oldest;
    r   = '0;
    lim = slots_in_use();
    case (act)
      ACT_PEEK: begin
        r.hit = find_tag(tag, lim) < lim;
      end
      ACT_GET: begin
        idx = find_tag(tag, lim);
        if (idx < lim) begin
          age_counter   = age_counter + 1;
          line_age[idx] = age_counter;
          r.hit         = 1'b1;
          r.data        = line_value[idx];
        end
      end
      ACT_PUT: begin
        if (val != '0) begin
          idx = find_tag(tag, lim);
          if (idx < lim) begin
            // present key: refresh only, value kept
            age_counter   = age_counter + 1;
            line_age[idx] = age_counter;
            r.hit         = 1'b1;
          end else begin
            if (live_lines() >= lim) begin
              oldest = lim;
              for (int i = 0; i < lim; i++)
                if (line_valid[i] && (oldest == lim || line_age[i] < line_age[oldest]))
                  oldest = i;
              if (oldest < lim) line_valid[oldest] = 1'b0;
              r.evicted = 1'b1;
            end
            for (int i = 0; i < lim; i++) begin
              if (!line_valid[i]) begin
                age_counter   = age_counter + 1;
                line_valid[i] = 1'b1;
                line_tag[i]   = tag;
                line_value[i] = val;
                line_age[i]   = age_counter;
                break;
              end
            end
          end
        end
      end
      ACT_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) line_valid[i] = 1'b0;
      end
      default: ;
    endcase
    r.occupied = CNT_W'(live_lines());
    replies_due.push_back(r);
  endtask

  task automatic check_reply();
    cache_reply_t want, got;
    got.hit      = m_tdata[0];
    got.data     = m_tdata[VALUE_W:1];
    got.evicted  = m_tdata[VALUE_W+1];
    got.occupied = m_tdata[VALUE_W+2 +: CNT_W];
    replies_seen++;
    if (got.hit) hits_seen++;
    if (got.evicted) evictions_seen++;
    if (replies_due.size() == 0) begin
      report_mismatch("reply with no item outstanding");
    end else begin
      want = replies_due.pop_front();
      if (got.hit !== want.hit)
        report_mismatch($sformatf("hit %0b, want %0b", got.hit, want.hit));
      if (got.data !== want.data)
        report_mismatch($sformatf("data %h, want %h", got.data, want.data));
      if (got.evicted !== want.evicted)
        report_mismatch($sformatf("evicted %0b, want %0b", got.evicted, want.evicted));
      if (got.occupied !== want.occupied)
        report_mismatch($sformatf("occupied_count %0d, want %0d", got.occupied, want.occupied));
    end
  endtask

  // Watch all three ports at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) line_valid[i] = 1'b0;
      age_counter    = '0;
      active_setting = ACTIVE_RESET;
      replies_due.delete();
    end else begin
      if (m_tvalid && m_tready) check_reply();
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_ACTIVE_SLOTS)
        set_active(pwdata);
      if (s_tvalid && s_tready)
        predict_access(s_tuser, s_tdata[KEY_W-1:0], s_tdata[KEY_W +: VALUE_W]);
      if (drain_check && !drained) begin
        drained = 1'b1;
        while (replies_due.size() != 0) begin
          void'(replies_due.pop_front());
          report_mismatch("reply never arrived");
        end
      end
    end
    pending = replies_due.size();
  end

endmodule

// File: tb/sv/testbench.sv
// Top of the LRU cache testbench: clock, reset, stimulus, register writes and verdict.
module testbench import lruc_pkg::*;;

  localparam int SLOTS     = 16;
  localparam int POOL_SIZE = 20;

  bit clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // key, value
  logic [ACT_W-1:0]     s_tuser;   // action
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // hit, data, evicted, occupied_count, zero pad
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 drain_check;

  int fail_count, pending, replies_seen, hits_seen, evictions_seen;
  int items_sent;
  int settings_used;
  bit tx_gaps, rx_gaps, hold_req;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  lru_associative_cache #(.SLOTS(SLOTS)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lru_cache_checker #(.SLOTS(SLOTS)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .drain_check(drain_check),
    .fail_count(fail_count), .pending(pending), .replies_seen(replies_seen),
    .hits_seen(hits_seen), .evictions_seen(evictions_seen)
  );

  always #6 clk = ~clk;

  // Hard stop if the run hangs
  initial begin
    #(12 * 400000);
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        hold_req = 1'b0;
        repeat (300) @(negedge clk);
      end else begin
        m_tready <= !(rx_gaps && $urandom_range(99) < 30);
        @(negedge clk);
      end
    end
  end

  // Offer one item and hold it until taken; returns at a falling edge
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] tag,
                           input logic [VALUE_W-1:0] val);
    if (tx_gaps && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {val, tag};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every reply is in
  task automatic drain_replies();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [PDATA_W-1:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_slots(input logic [CNT_W-1:0] n);
    drain_replies();
    reg_write({REG_ACTIVE_SLOTS, 2'b00}, ({$urandom} << CNT_W) | PDATA_W'(n));
    settings_used++;
  endtask

  task automatic refill_pool();
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    if ($urandom_range(1)) key_pool[0] = '0;
    if ($urandom_range(1)) key_pool[1] = '1;
  endtask

  // Mostly pooled keys so hits and evictions are common
  task automatic random_items(input int count, input bit pause_midway, input bit hold_midway);
    int               roll;
    logic [ACT_W-1:0] act;
    logic [KEY_W-1:0] tag;
    logic [VALUE_W-1:0] val;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) begin
        if (pause_midway) drain_replies();
        if (hold_midway) hold_req = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 25)      act = ACT_PEEK;
      else if (roll < 55) act = ACT_GET;
      else if (roll < 97) act = ACT_PUT;
      else                act = ACT_CLEAR;
      tag  = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
      roll = $urandom_range(99);
      if (roll < 5)       val = '0;
      else if (roll < 10) val = '1;
      else                val = $urandom;
      send_item(act, tag, val);
    end
  endtask

  initial begin
    logic [CNT_W-1:0] plan [10];
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = ACT_PEEK;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    drain_check = 1'b0;
    tx_gaps     = 1'b1;
    rx_gaps     = 1'b1;
    hold_req    = 1'b0;
    items_sent    = 0;
    settings_used = 1;
    plan = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd16, 5'd7, 5'd3, 5'd0, 5'd12, 5'd16};
    plan[7] = CNT_W'($urandom_range(31));
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty cache, extreme keys and values, every action
    send_item(ACT_PEEK,  32'h0, 32'h0);
    send_item(ACT_GET,   32'h0, 32'h0);
    send_item(ACT_PUT,   32'h0, 32'h0);            // zero value rejected
    send_item(ACT_PUT,   32'h0, 32'h1);
    send_item(ACT_PUT,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_PEEK,  32'h0, 32'h0);
    send_item(ACT_GET,   32'hFFFF_FFFF, 32'h0);
    send_item(ACT_PUT,   32'h0, 32'h5);            // present key keeps old value
    send_item(ACT_GET,   32'h0, 32'h0);
    send_item(ACT_CLEAR, 32'h0, 32'h0);
    send_item(ACT_PEEK,  32'h0, 32'h0);

    // Two slots: eviction of the oldest, full cache rejecting a zero value
    set_slots(5'd2);
    send_item(ACT_PUT,  32'hA5A5_0001, 32'h1111_0000);
    send_item(ACT_PUT,  32'h5A5A_0002, 32'h2222_0000);
    send_item(ACT_GET,  32'hA5A5_0001, 32'h0);
    send_item(ACT_PUT,  32'h0F0F_0003, 32'h3333_0000);
    send_item(ACT_PEEK, 32'h5A5A_0002, 32'h0);
    send_item(ACT_PUT,  32'h0F0F_0004, 32'h0);

    // Zero setting acts as one slot; shrinking drops the upper slot
    set_slots(5'd0);
    send_item(ACT_PEEK, 32'h0F0F_0003, 32'h0);
    send_item(ACT_PUT,  32'hC3C3_0005, 32'h5555_0000);
    send_item(ACT_PUT,  32'h3C3C_0006, 32'h6666_0000);
    send_item(ACT_GET,  32'h3C3C_0006, 32'h0);

    // An unmapped register address is ignored
    drain_replies();
    reg_write(3'd4, 32'd1);

    // Random phases across slot settings
    for (int p = 0; p < 10; p++) begin
      set_slots(plan[p]);
      refill_pool();
      tx_gaps = (p != 4);
      rx_gaps = (p != 4);
      random_items(103, p == 2, p == 6);
    end

    drain_replies();
    repeat (40) @(negedge clk);
    drain_check <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    $display("covered %0d items over %0d slot settings, %0d replies checked",
             items_sent, settings_used, replies_seen);
    $display("replies with hits: %0d, with evictions: %0d", hits_seen, evictions_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
